// ----- hw/rtl/a64mae_pkg.sv -----
// Package for the AArch64 memory-access encoder: request kinds, word phases,
// address modes and the instruction-word formatting functions.
// No dependencies.
package a64mae_pkg;

  // Request kinds as carried on the input channel.
  localparam logic [3:0] KIND_LDB = 4'd0;
  localparam logic [3:0] KIND_LDH = 4'd1;
  localparam logic [3:0] KIND_LDW = 4'd2;
  localparam logic [3:0] KIND_LDX = 4'd3;
  localparam logic [3:0] KIND_STB = 4'd4;
  localparam logic [3:0] KIND_STH = 4'd5;
  localparam logic [3:0] KIND_STW = 4'd6;
  localparam logic [3:0] KIND_STX = 4'd7;
  localparam logic [3:0] KIND_LDQ = 4'd8;
  localparam logic [3:0] KIND_STQ = 4'd9;
  localparam logic [3:0] KIND_ADR = 4'd10;

  // Word phases of one request, in emission order; one bit each in the
  // remaining-word mask.
  localparam int unsigned NUM_PHASES = 6;
  localparam logic [2:0] PH_MOV0 = 3'd0;
  localparam logic [2:0] PH_MOV1 = 3'd1;
  localparam logic [2:0] PH_MOV2 = 3'd2;
  localparam logic [2:0] PH_MOV3 = 3'd3;
  localparam logic [2:0] PH_ADDR = 3'd4;
  localparam logic [2:0] PH_ACC  = 3'd5;

  // How the address is formed from base and displacement.
  localparam logic [1:0] MODE_ZERO  = 2'd0;
  localparam logic [1:0] MODE_SMALL = 2'd1;
  localparam logic [1:0] MODE_SHIFT = 2'd2;
  localparam logic [1:0] MODE_LARGE = 2'd3;

  // Move-wide opcodes.
  localparam logic [1:0] OPC_MOVZ = 2'd2;
  localparam logic [1:0] OPC_MOVK = 2'd3;

  localparam logic [4:0] SCRATCH_A = 5'd8;
  localparam logic [4:0] SCRATCH_B = 5'd9;

  localparam logic [31:0] ADD_REG_BASE = 32'h8B00_0000;
  localparam logic [5:0]  ADDSUB_IMM_OP = 6'h22;
  localparam logic [5:0]  MOVE_WIDE_OP  = 6'h25;
  localparam logic [11:0] IMM12_MAX     = 12'd4095;

  typedef logic [NUM_PHASES-1:0] phase_mask_t;

  // Opcode template of the unsigned-offset load/store for an access kind.
  function automatic logic [31:0] access_base(input logic [3:0] kind);
    logic [31:0] w;
    begin
      case (kind)
        KIND_LDB: w = 32'h3940_0000;
        KIND_LDH: w = 32'h7940_0000;
        KIND_LDW: w = 32'hB940_0000;
        KIND_LDX: w = 32'hF940_0000;
        KIND_STB: w = 32'h3900_0000;
        KIND_STH: w = 32'h7900_0000;
        KIND_STW: w = 32'hB900_0000;
        KIND_STX: w = 32'hF900_0000;
        KIND_LDQ: w = 32'h3DC0_0000;
        KIND_STQ: w = 32'h3D80_0000;
        default:  w = 32'h0000_0000;
      endcase
      return w;
    end
  endfunction

  // Log2 of the access size in bytes.
  function automatic logic [2:0] access_log2(input logic [3:0] kind);
    logic [2:0] lg;
    begin
      case (kind) inside
        KIND_LDQ, KIND_STQ: lg = 3'd4;
        default:            lg = {1'b0, kind[1:0]};
      endcase
      return lg;
    end
  endfunction

  // ADD/SUB (immediate), 64-bit.
  function automatic logic [31:0] add_sub_imm_word(input logic sub, input logic [4:0] rd,
                                                   input logic [4:0] rn,
                                                   input logic [11:0] imm12,
                                                   input logic sh);
    return {1'b1, sub, 1'b0, ADDSUB_IMM_OP, sh, imm12, rn, rd};
  endfunction

  // MOVZ/MOVK, 64-bit.
  function automatic logic [31:0] move_wide_word(input logic [1:0] opc, input logic [1:0] hw,
                                                 input logic [15:0] imm16,
                                                 input logic [4:0] rd);
    return {1'b1, opc, MOVE_WIDE_OP, hw, imm16, rd};
  endfunction

endpackage

// ----- hw/rtl/a64_memory_access_encoder_top.sv -----
// Top level of the AArch64 memory-access encoder: request register, word
// sequencer and output register.
// Depends on a64mae_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request word: kind, data
//   register, base register and a signed 32-bit displacement. The result
//   channel (out_valid/out_ready) gives one instruction word per handshake,
//   with out_last_word high on the final word of a request.
//   A request whose displacement fits the unsigned-offset form yields one
//   word; ADD/SUB immediate forms yield two words for an access and one for
//   an address add; large displacements yield up to six words (moves, a
//   register ADD and the access). Unused kinds yield no words.
//   The request is registered first; its first word then moves to the output register.
//   Throughput is one word per cycle while the receiver is ready, set by the
//   single word sequencer that emits one word of the held request each cycle;
//   a new request is taken in the cycle the previous request's last word moves
//   to the output register, so one-word requests stream at one per cycle.
//   When the receiver stalls, the output register holds its word and the
//   sequencer and input back up behind it. Reset empties both registers.
module a64_memory_access_encoder_top
  import a64mae_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_kind,
  input  logic [4:0]  in_data_reg,
  input  logic [4:0]  in_base_reg,
  input  logic signed [31:0] in_displacement,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_instr_word,
  output logic        out_last_word
);

  // Held request and its pending word mask.
  phase_mask_t rem_r, rem_nxt;
  logic [3:0]  movs_r, movs_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [4:0]  rt_r, rt_nxt;
  logic [4:0]  rn_r, rn_nxt;
  logic [31:0] disp_r, disp_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        direct_r, direct_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic        out_last_r, out_last_nxt;

  // Classification of the incoming request.
  logic        in_fire;
  logic [31:0] in_disp_u;
  logic        in_neg;
  logic [31:0] in_mag;
  logic [1:0]  in_mode;
  logic [2:0]  in_lg;
  logic [31:0] in_low_mask;
  logic [31:0] in_scaled;
  logic        in_is_acc;
  logic        in_direct;
  logic        in_need_addr;
  phase_mask_t in_mask;
  logic [3:0]  in_movs;

  assign in_disp_u   = in_displacement;
  assign in_neg      = in_disp_u[31];
  assign in_mag      = in_neg ? (32'd0 - in_disp_u) : in_disp_u;
  assign in_lg       = access_log2(in_kind);
  assign in_low_mask = (32'd1 << in_lg) - 32'd1;
  assign in_scaled   = in_disp_u >> in_lg;
  assign in_is_acc   = (in_kind < KIND_ADR);
  assign in_direct   = in_is_acc && !in_neg && ((in_disp_u & in_low_mask) == 32'd0) &&
                       (in_scaled <= {20'd0, IMM12_MAX});
  assign in_need_addr = (in_kind == KIND_ADR) || (in_is_acc && !in_direct);

  always_comb begin
    if (in_disp_u == 32'd0) begin
      in_mode = MODE_ZERO;
    end else if (in_mag <= {20'd0, IMM12_MAX}) begin
      in_mode = MODE_SMALL;
    end else if ((in_mag[11:0] == 12'd0) && (in_mag[31:24] == 8'd0)) begin
      in_mode = MODE_SHIFT;
    end else begin
      in_mode = MODE_LARGE;
    end
  end

  // Moves are needed for every nonzero 16-bit chunk of the sign-extended value.
  assign in_movs = (in_need_addr && (in_mode == MODE_LARGE)) ?
                   {in_neg, in_neg, (in_disp_u[31:16] != 16'd0), (in_disp_u[15:0] != 16'd0)} :
                   4'd0;
  assign in_mask = {in_is_acc, in_need_addr, in_movs};

  // Current word: lowest pending phase.
  logic [2:0]  cur_ph;
  phase_mask_t cur_onehot;
  logic        cur_last;
  logic        emit;
  logic        neg_w;
  logic [4:0]  dst_w;
  logic [4:0]  tmp_w;
  logic        wrote_w;
  logic [15:0] chunk_w;
  logic [31:0] addr_word;
  logic [31:0] acc_word;
  logic [31:0] cur_word;
  logic [2:0]  lg_w;
  logic        direct_w;

  always_comb begin
    cur_ph = PH_ACC;
    for (int i = NUM_PHASES - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        cur_ph = 3'(i);
      end
    end
  end

  assign cur_onehot = phase_mask_t'(1) << cur_ph;
  assign cur_last   = ((rem_r & ~cur_onehot) == '0);
  assign emit       = (rem_r != '0) && (!out_valid_r || out_ready);
  assign in_ready   = (rem_r == '0) || (emit && cur_last);
  assign in_fire    = in_valid && in_ready;

  assign neg_w    = disp_r[31];
  assign dst_w    = (kind_r == KIND_ADR) ? rt_r : SCRATCH_A;
  assign tmp_w    = (dst_w == SCRATCH_A) ? SCRATCH_B : SCRATCH_A;
  assign wrote_w  = ((movs_r & ~rem_r[3:0]) != 4'd0);
  assign lg_w     = access_log2(kind_r);
  assign direct_w = direct_r;

  always_comb begin
    if (cur_ph[1]) begin
      chunk_w = {16{neg_w}};
    end else if (cur_ph[0]) begin
      chunk_w = disp_r[31:16];
    end else begin
      chunk_w = disp_r[15:0];
    end
  end

  // Address word: immediate forms or register ADD with the scratch register.
  always_comb begin
    case (mode_r)
      MODE_ZERO:  addr_word = add_sub_imm_word(1'b0, dst_w, rn_r, 12'd0, 1'b0);
      MODE_SMALL: addr_word = add_sub_imm_word(neg_w, dst_w, rn_r, mag_r[11:0], 1'b0);
      MODE_SHIFT: addr_word = add_sub_imm_word(neg_w, dst_w, rn_r, mag_r[23:12], 1'b1);
      default:    addr_word = ADD_REG_BASE | ({27'd0, tmp_w} << 16) |
                              ({27'd0, rn_r} << 5) | {27'd0, dst_w};
    endcase
  end

  // Access word: direct offset, or zero offset from the scratch address.
  always_comb begin
    if (direct_w) begin
      acc_word = access_base(kind_r) | ({20'd0, disp_r[11 + lg_w -: 12] & IMM12_MAX} << 10) |
                 ({27'd0, rn_r} << 5) | {27'd0, rt_r};
    end else begin
      acc_word = access_base(kind_r) | ({27'd0, SCRATCH_A} << 5) | {27'd0, rt_r};
    end
  end

  always_comb begin
    unique case (cur_ph)
      PH_MOV0, PH_MOV1, PH_MOV2, PH_MOV3:
        cur_word = move_wide_word(wrote_w ? OPC_MOVK : OPC_MOVZ, cur_ph[1:0], chunk_w, tmp_w);
      PH_ADDR: cur_word = addr_word;
      PH_ACC:  cur_word = acc_word;
      default: cur_word = acc_word;
    endcase
  end

  // Next-state logic for the request and output registers.
  always_comb begin
    rem_nxt       = rem_r;
    movs_nxt      = movs_r;
    kind_nxt      = kind_r;
    rt_nxt        = rt_r;
    rn_nxt        = rn_r;
    disp_nxt      = disp_r;
    mag_nxt       = mag_r;
    mode_nxt      = mode_r;
    direct_nxt    = direct_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      rem_nxt       = rem_r & ~cur_onehot;
      out_valid_nxt = 1'b1;
      out_word_nxt  = cur_word;
      out_last_nxt  = cur_last;
    end
    if (in_fire) begin
      rem_nxt    = in_mask;
      movs_nxt   = in_movs;
      kind_nxt   = in_kind;
      rt_nxt     = in_data_reg;
      rn_nxt     = in_base_reg;
      disp_nxt   = in_disp_u;
      mag_nxt    = in_mag;
      mode_nxt   = in_mode;
      direct_nxt = in_direct;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    movs_r     <= movs_nxt;
    kind_r     <= kind_nxt;
    rt_r       <= rt_nxt;
    rn_r       <= rn_nxt;
    disp_r     <= disp_nxt;
    mag_r      <= mag_nxt;
    mode_r     <= mode_nxt;
    direct_r   <= direct_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_instr_word = out_word_r;
  assign out_last_word  = out_last_r;

  // A request still holding words must block the input.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    ((rem_r != '0) && !(emit && cur_last)) |-> !in_ready)
    else $error("input accepted while a request still has words pending");

  // Move words only exist for the large-displacement form.
  a_movs_large: assert property (@(posedge clk) disable iff (!rst_n)
    ((rem_r[3:0] & movs_r) != 4'd0) |-> (mode_r == MODE_LARGE))
    else $error("move words pending outside the large-displacement form");

  // Pending moves are always a subset of the request's move set.
  a_movs_subset: assert property (@(posedge clk) disable iff (!rst_n)
    ((rem_r[3:0] & ~movs_r) == 4'd0))
    else $error("pending move word outside the request's move set");

  // An emitted word shows up on the output in the next cycle.
  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid && (out_last_word == $past(cur_last))))
    else $error("emitted word missing from the output register");

endmodule

// ----- tb/sv/a64_memory_access_encoder_top_tb.sv -----
// Testbench for a64_memory_access_encoder_top: streams load, store and address requests,
// predicts every emitted instruction word and checks each word in order on the result side.
// Depends on a64mae_pkg and the encoder top level.
`timescale 1ns / 100ps

module a64_memory_access_encoder_top_tb
  import a64mae_pkg::*;
();

  localparam logic [3:0] KIND_UNUSED_LO = 4'd11;
  localparam logic [3:0] KIND_UNUSED_HI = 4'd15;
  localparam int unsigned RANDOM_REQUESTS = 270;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [3:0]  kind;
    logic [4:0]  data_reg;
    logic [4:0]  base_reg;
    logic [31:0] disp;
  } mem_request_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } encoded_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_kind = '0;
  logic [4:0] in_data_reg = '0;
  logic [4:0] in_base_reg = '0;
  logic [31:0] in_displacement = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_instr_word;
  logic out_last_word;

  mem_request_t request_queue[$];
  encoded_word_t due_words[$];
  logic [31:0] word_build[$];

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int unsigned in_gap = 0;
  int unsigned in_run = 0;
  bit in_calm = 1'b0;
  int unsigned out_wait = 0;
  int unsigned out_run = 0;
  bit out_calm = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned mismatch_count = 0;
  mem_request_t drive_req;
  encoded_word_t head_word;

  a64_memory_access_encoder_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_data_reg    (in_data_reg),
    .in_base_reg    (in_base_reg),
    .in_displacement(in_displacement),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_instr_word (out_instr_word),
    .out_last_word  (out_last_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Waits come in runs: either all zero, or drawn from 0 to 12.
  function automatic int unsigned draw_wait(inout int unsigned run, inout bit calm);
    if (run == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      run = $urandom_range(8, 30);
    end
    run--;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // Base register plus displacement into dst, appended to word_build.
  function automatic void form_address(logic [4:0] dst, logic [4:0] base, logic [31:0] disp);
    logic neg;
    logic [31:0] mag;
    logic [63:0] wide;
    logic [4:0] tmp;
    logic [15:0] chunk;
    bit wrote;
    neg = disp[31];
    mag = neg ? (32'd0 - disp) : disp;
    wrote = 1'b0;
    if (disp == 32'd0) begin
      word_build.push_back({1'b1, 1'b0, 1'b0, 6'h22, 1'b0, 12'd0, base, dst});
    end else if (mag <= 32'd4095) begin
      word_build.push_back({1'b1, neg, 1'b0, 6'h22, 1'b0, mag[11:0], base, dst});
    end else if (mag[11:0] == 12'd0 && mag[31:12] <= 20'd4095) begin
      word_build.push_back({1'b1, neg, 1'b0, 6'h22, 1'b1, mag[23:12], base, dst});
    end else begin
      // The temporary must not collide with the destination.
      tmp = (dst == SCRATCH_A) ? SCRATCH_B : SCRATCH_A;
      wide = {{32{disp[31]}}, disp};
      for (int i = 0; i < 4; i++) begin
        chunk = wide[16*i +: 16];
        if (chunk == 16'd0 && !(i == 3 && !wrote)) continue;
        word_build.push_back({1'b1, (wrote ? OPC_MOVK : OPC_MOVZ), 6'h25, 2'(i), chunk, tmp});
        wrote = 1'b1;
      end
      word_build.push_back({1'b1, 2'b00, 5'h0B, 3'b000, tmp, 6'd0, base, dst});
    end
  endfunction

  // Expected instruction words of one request, queued with the final word flagged.
  function automatic void encode_request(mem_request_t req);
    logic [31:0] tmpl;
    logic [31:0] scaled;
    logic [31:0] mask;
    int unsigned lg;
    int unsigned n;
    word_build.delete();
    if (req.kind == KIND_ADR) begin
      form_address(req.data_reg, req.base_reg, req.disp);
    end else if (req.kind < KIND_ADR) begin
      // Unsigned-offset load/store: size, class bits, then opc (load or store).
      if (req.kind == KIND_LDQ || req.kind == KIND_STQ) begin
        lg = 4;
        tmpl = {2'b00, 6'b111101, 1'b1, (req.kind == KIND_LDQ), 22'd0};
      end else begin
        lg = req.kind[1:0];
        tmpl = {req.kind[1:0], 6'b111001, 1'b0, (req.kind < KIND_STB), 22'd0};
      end
      mask = (32'd1 << lg) - 32'd1;
      scaled = req.disp >> lg;
      if (!req.disp[31] && (req.disp & mask) == 32'd0 && scaled <= 32'd4095) begin
        word_build.push_back(tmpl | {10'd0, scaled[11:0], req.base_reg, req.data_reg});
      end else begin
        // The address goes to X8 even when X8 is also the data register.
        form_address(SCRATCH_A, req.base_reg, req.disp);
        word_build.push_back(tmpl | {10'd0, 12'd0, SCRATCH_A, req.data_reg});
      end
    end
    n = word_build.size();
    for (int unsigned i = 0; i < n; i++) begin
      due_words.push_back('{word: word_build[i], last: (i == n - 1)});
    end
  endfunction

  function automatic void add_request(logic [3:0] kind, logic [4:0] rt, logic [4:0] rn,
                                      logic [31:0] disp);
    request_queue.push_back('{kind: kind, data_reg: rt, base_reg: rn, disp: disp});
  endfunction

  // Registers lean toward the scratch pair, SP and X0.
  function automatic logic [4:0] random_reg();
    logic [4:0] picks[4];
    picks = '{5'd8, 5'd9, 5'd31, 5'd0};
    if ($urandom_range(0, 3) == 0) return picks[$urandom_range(0, 3)];
    return 5'($urandom_range(0, 31));
  endfunction

  // Displacements spread over every address form.
  function automatic logic [31:0] random_disp(logic [3:0] kind);
    logic [31:0] d;
    logic [31:0] edges[8];
    logic [15:0] hi;
    int unsigned lg;
    edges = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd4095, 32'd4096,
              32'hFFFF_F001, 32'h00FF_F000};
    lg = (kind == KIND_LDQ || kind == KIND_STQ) ? 4 : (kind < KIND_ADR ? kind[1:0] : 0);
    case ($urandom_range(0, 9))
      0, 1: d = 32'($urandom_range(0, 4095)) << lg;
      2: d = 32'($urandom_range(1, 4095));
      3: d = 32'($urandom_range(1, 4095)) << 12;
      4, 5: d = $urandom;
      6, 7: begin
        case ($urandom_range(0, 2))
          0: hi = 16'h0000;
          1: hi = 16'hFFFF;
          default: hi = 16'($urandom);
        endcase
        d = {hi, ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom)};
      end
      8: d = 32'($urandom_range(4096, 32'h0100_0000));
      default: d = edges[$urandom_range(0, 7)];
    endcase
    if ($urandom_range(0, 2) == 0 &&
        $urandom_range(0, 9) < 2 + (d != 32'($urandom_range(0, 4095)) << lg))
      d = 32'd0 - d;
    return d;
  endfunction

  // Stimulus, reset and the end of the run.
  initial begin
    int unsigned accepted_kinds;
    mem_request_t req;
    // Directed: aligned extremes, each address form, the six-word case and unused kinds.
    add_request(KIND_LDB, 5'd0, 5'd31, 32'd0);
    add_request(KIND_LDH, 5'd1, 5'd2, 32'd8190);
    add_request(KIND_LDW, 5'd31, 5'd31, 32'd16380);
    add_request(KIND_LDX, 5'd3, 5'd4, 32'd32760);
    add_request(KIND_STB, 5'd5, 5'd6, 32'd4095);
    add_request(KIND_STH, 5'd7, 5'd8, 32'd1);
    add_request(KIND_STW, 5'd9, 5'd10, 32'd16384);
    add_request(KIND_STX, 5'd11, 5'd31, 32'hFFFF_FFF8);
    add_request(KIND_LDQ, 5'd31, 5'd12, 32'd65520);
    add_request(KIND_STQ, 5'd0, 5'd13, 32'd65536);
    add_request(KIND_ADR, 5'd31, 5'd31, 32'd0);
    add_request(KIND_ADR, 5'd14, 5'd15, 32'hFFFF_F001);
    add_request(KIND_ADR, 5'd16, 5'd17, 32'h00FF_F000);
    add_request(KIND_ADR, 5'd18, 5'd19, 32'hFF00_1000);
    add_request(KIND_ADR, 5'd20, 5'd21, 32'h0100_0000);
    add_request(KIND_ADR, 5'd22, 5'd23, 32'h7FFF_FFFF);
    add_request(KIND_ADR, 5'd24, 5'd31, 32'h8000_0000);
    add_request(KIND_LDX, 5'd8, 5'd25, 32'h1234_5679);
    add_request(KIND_ADR, 5'd8, 5'd8, 32'h0001_2345);
    add_request(KIND_STB, 5'd26, 5'd27, 32'hFFFF_FFFF);
    add_request(KIND_LDW, 5'd28, 5'd29, 32'h0001_0000);
    add_request(KIND_LDB, 5'd30, 5'd9, 32'h0001_1111);
    add_request(KIND_STQ, 5'd8, 5'd31, 32'hFFFE_DCBB);
    add_request(KIND_UNUSED_LO, 5'd31, 5'd31, 32'hFFFF_FFFF);
    add_request(4'd12, 5'd8, 5'd0, 32'd16);
    add_request(KIND_UNUSED_HI, 5'd0, 5'd8, 32'h8000_0000);
    add_request(KIND_LDB, 5'd2, 5'd3, 32'd4096);

    // Random part; unused kinds are mixed in but not counted.
    accepted_kinds = 0;
    while (accepted_kinds < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 19) == 0)
        req.kind = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      else
        req.kind = 4'($urandom_range(0, KIND_ADR));
      req.data_reg = random_reg();
      req.base_reg = random_reg();
      req.disp = random_disp(req.kind);
      request_queue.push_back(req);
      if (req.kind <= KIND_ADR) accepted_kinds++;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (request_queue.size() != 0 || in_valid || due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Request driver: one word held until taken, then an optional gap.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          drive_req = request_queue.pop_front();
          in_kind <= drive_req.kind;
          in_data_reg <= drive_req.data_reg;
          in_base_reg <= drive_req.base_reg;
          in_displacement <= drive_req.disp;
          in_valid <= 1'b1;
          in_gap = draw_wait(in_run, in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result-side ready: a stall drawn after every word taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) begin
        out_wait = draw_wait(out_run, out_calm);
        out_ready <= (out_wait == 0);
      end else if (out_wait > 0) begin
        out_wait--;
        out_ready <= (out_wait == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts accepted requests, checks each result word, and runs the watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      out_took <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        encode_request('{kind: in_kind, data_reg: in_data_reg, base_reg: in_base_reg,
                         disp: in_displacement});
      end
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual %h last %b", $time,
                   out_instr_word, out_last_word);
          mismatch_count++;
        end else begin
          head_word = due_words.pop_front();
          if (out_instr_word !== head_word.word) begin
            $display("%0t: instr_word mismatch: expected %h, actual %h", $time,
                     head_word.word, out_instr_word);
            mismatch_count++;
          end
          if (out_last_word !== head_word.last) begin
            $display("%0t: last_word mismatch: expected %b, actual %b", $time,
                     head_word.last, out_last_word);
            mismatch_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

endmodule

// ----- a64_memory_access_encoder_top.f -----
hw/rtl/a64mae_pkg.sv
hw/rtl/a64_memory_access_encoder_top.sv
tb/sv/a64_memory_access_encoder_top_tb.sv
